// File: rtl/limit_order_book_matcher_core_macros.svh
// Assertion macros used by the RTL file that carries checks.
// Every macro expects signals named clk and rst in the scope where it is used.
`ifndef LIMIT_ORDER_BOOK_MATCHER_CORE_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LOBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define LOBM_ASSERT_IMPL(label, ante, cons, msg) \
  `LOBM_ASSERT(label, (ante) |-> (cons), msg)

// A consequence that must hold in the cycle after its antecedent.
`define LOBM_ASSERT_NEXT(label, ante, cons, msg) \
  `LOBM_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: rtl/lobm_pkg.sv
package lobm_pkg;

  localparam int ORDER_SLOTS = 64;
  localparam int SLOT_BITS   = $clog2(ORDER_SLOTS);
  localparam int CNT_BITS    = $clog2(ORDER_SLOTS + 1);
  localparam int PRICE_BITS  = 20;
  localparam int ID_BITS     = 64;
  localparam int QTY_BITS    = 32;
  localparam int SEQ_BITS    = 32;
  localparam int LVL_BITS    = QTY_BITS + SLOT_BITS;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_MARKET = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_FILL   = 2'd2,
    KIND_NOFILL = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ID_SCAN,
    ST_ID_DONE,
    ST_PICK_SCAN,
    ST_FILL,
    ST_TOP_SCAN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  // One resting order as held in the slot memory.
  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   rem;
    logic [SEQ_BITS-1:0]   stamp;
  } slot_t;

  // One fill of a market order, held until the book top is known.
  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
    logic [SEQ_BITS-1:0]   stamp;
  } fill_t;

endpackage

// File: rtl/lobm_if.sv
interface lobm_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      op;
  logic [lobm_pkg::ID_BITS-1:0]    order_id;
  logic                            side;
  logic [lobm_pkg::PRICE_BITS-1:0] price_ticks;
  logic [lobm_pkg::QTY_BITS-1:0]   quantity;

  modport source (output valid, op, order_id, side, price_ticks, quantity, input ready);
  modport sink (input valid, op, order_id, side, price_ticks, quantity, output ready);
endinterface

interface lobm_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic                            accepted;
  logic [lobm_pkg::ID_BITS-1:0]    resting_id;
  logic [lobm_pkg::SEQ_BITS-1:0]   taker_id;
  logic [lobm_pkg::PRICE_BITS-1:0] fill_price;
  logic [lobm_pkg::QTY_BITS-1:0]   fill_qty;
  logic [lobm_pkg::SEQ_BITS-1:0]   trade_stamp;
  logic [lobm_pkg::PRICE_BITS-1:0] best_bid;
  logic [lobm_pkg::LVL_BITS-1:0]   bid_qty;
  logic [lobm_pkg::PRICE_BITS-1:0] best_ask;
  logic [lobm_pkg::LVL_BITS-1:0]   ask_qty;
  logic                            last;

  modport source (output valid, kind, accepted, resting_id, taker_id, fill_price, fill_qty,
                  trade_stamp, best_bid, bid_qty, best_ask, ask_qty, last, input ready);
  modport sink (input valid, kind, accepted, resting_id, taker_id, fill_price, fill_qty,
                trade_stamp, best_bid, bid_qty, best_ask, ask_qty, last, output ready);
endinterface

// File: rtl/limit_order_book_matcher_core.sv
// Limit order book matcher with price-time priority over a table of order slots.
// Channel req carries one command item: add a limit order, cancel an order by id,
// or a market order that takes the opposite side, best price and then oldest first.
// Channel rsp returns the result items of that command: one add or cancel result,
// or one fill per resting order touched (or a single no-fill result), each carrying
// the book top as it stands after the whole command, with last marking the final one.
// One command is worked on at a time and req.ready is low until its last result item
// has been taken. Each slot scan reads the slot memory once per slot, and an add or
// cancel takes two scans (id lookup, book top) before its result item. A market
// order with F fills takes F + 1 scans (one more when the opposite side runs dry),
// and each result item then passes through EMIT_RD, EMIT_LD (load of the result
// register) and EMIT_WAIT (wait for rsp.ready).
// A stall on rsp simply holds the result register; no work is lost.
// An undefined op code is accepted and dropped without any result.
// Reset (synchronous, active high) empties the book at once by clearing the slot
// valid bits, and zeroes the sequence counter; no clearing pass is needed.
`include "limit_order_book_matcher_core_macros.svh"

module limit_order_book_matcher_core (
  input logic       clk,
  input logic       rst,
  lobm_in_if.sink   req,
  lobm_out_if.source rsp
);

  // Control state.
  lobm_pkg::state_t state, state_next;
  logic [lobm_pkg::ORDER_SLOTS-1:0] valid_bits;
  logic [lobm_pkg::SEQ_BITS-1:0]    seq;

  // The command being worked on.
  lobm_pkg::op_t                    op_q;
  logic [lobm_pkg::ID_BITS-1:0]     id_q;
  logic                             side_q;
  logic [lobm_pkg::PRICE_BITS-1:0]  price_q;
  logic [lobm_pkg::QTY_BITS-1:0]    left;
  logic [lobm_pkg::SEQ_BITS-1:0]    taker;
  logic                             accepted_q;

  // Slot scan sequencing: one read issued per cycle, its data back in the next cycle.
  logic [lobm_pkg::CNT_BITS-1:0]    issue_idx;
  logic                             pipe_vld;
  logic [lobm_pkg::SLOT_BITS-1:0]   pipe_idx;
  logic                             issuing;
  logic                             scan_done;
  logic                             cand;

  // Id lookup results.
  logic                             hit;
  logic [lobm_pkg::SLOT_BITS-1:0]   hit_idx;
  logic                             free_found;
  logic [lobm_pkg::SLOT_BITS-1:0]   free_idx;

  // Front of the opposite side for a market order.
  logic                             pick_found;
  logic [lobm_pkg::SLOT_BITS-1:0]   pick_idx;
  lobm_pkg::slot_t                  pick_rec;
  logic [lobm_pkg::SEQ_BITS-1:0]    pick_age;
  logic [lobm_pkg::SEQ_BITS-1:0]    age;
  logic                             better;

  // Fill bookkeeping.
  logic [lobm_pkg::CNT_BITS-1:0]    fill_cnt;
  logic [lobm_pkg::QTY_BITS-1:0]    fq;
  logic [lobm_pkg::QTY_BITS-1:0]    rem_after;
  logic [lobm_pkg::QTY_BITS-1:0]    left_after;
  logic [lobm_pkg::CNT_BITS-1:0]    cnt_inc;
  logic                             more_fills;
  logic [lobm_pkg::SEQ_BITS-1:0]    seq_inc;

  // Book top.
  logic                             bid_found, ask_found;
  logic [lobm_pkg::PRICE_BITS-1:0]  bb, ba;
  logic [lobm_pkg::LVL_BITS-1:0]    bq, aq;

  // Result emission.
  logic [lobm_pkg::CNT_BITS-1:0]    emit_idx;
  logic [lobm_pkg::CNT_BITS-1:0]    n_res;
  logic                             emit_last;
  logic                             add_ok;

  // Memory ports.
  logic                             slot_we;
  logic [lobm_pkg::SLOT_BITS-1:0]   slot_waddr, slot_raddr;
  lobm_pkg::slot_t                  slot_wdata, slot_rd;
  logic                             fill_we;
  logic [lobm_pkg::SLOT_BITS-1:0]   fill_waddr, fill_raddr;
  lobm_pkg::fill_t                  fill_wdata, fill_rd;

  lobm_ram #(
    .WIDTH($bits(lobm_pkg::slot_t)),
    .DEPTH(lobm_pkg::ORDER_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .raddr(slot_raddr),
    .rdata(slot_rd)
  );

  lobm_ram #(
    .WIDTH($bits(lobm_pkg::fill_t)),
    .DEPTH(lobm_pkg::ORDER_SLOTS)
  ) u_fill_ram (
    .clk  (clk),
    .we   (fill_we),
    .waddr(fill_waddr),
    .wdata(fill_wdata),
    .raddr(fill_raddr),
    .rdata(fill_rd)
  );

  // Shared scan datapath.
  always_comb begin
    issuing   = issue_idx < lobm_pkg::CNT_BITS'(lobm_pkg::ORDER_SLOTS);
    scan_done = !issuing && !pipe_vld;
    cand      = pipe_vld && valid_bits[pipe_idx];
    seq_inc   = seq + lobm_pkg::SEQ_BITS'(1);
    age       = seq - slot_rd.stamp;
    // Bids rank by highest price, asks by lowest; then the greater age wins.
    if (!pick_found) begin
      better = 1'b1;
    end else if (slot_rd.price == pick_rec.price) begin
      better = age > pick_age;
    end else if (side_q) begin
      better = slot_rd.price > pick_rec.price;
    end else begin
      better = slot_rd.price < pick_rec.price;
    end
    fq         = (left < pick_rec.rem) ? left : pick_rec.rem;
    rem_after  = pick_rec.rem - fq;
    left_after = left - fq;
    cnt_inc    = fill_cnt + lobm_pkg::CNT_BITS'(1);
    more_fills = (left_after != '0) && (cnt_inc < lobm_pkg::CNT_BITS'(lobm_pkg::ORDER_SLOTS));
    add_ok     = (left != '0) && (price_q != '0) && !hit && free_found;
    if (op_q == lobm_pkg::OP_MARKET && fill_cnt != '0) begin
      n_res = fill_cnt;
    end else begin
      n_res = lobm_pkg::CNT_BITS'(1);
    end
    emit_last = (emit_idx + lobm_pkg::CNT_BITS'(1)) >= n_res;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lobm_pkg::ST_IDLE: begin
        if (req.valid) begin
          case (lobm_pkg::op_t'(req.op))
            lobm_pkg::OP_ADD, lobm_pkg::OP_CANCEL: state_next = lobm_pkg::ST_ID_SCAN;
            lobm_pkg::OP_MARKET: begin
              state_next = (req.quantity != '0) ? lobm_pkg::ST_PICK_SCAN
                                                : lobm_pkg::ST_TOP_SCAN;
            end
            default: state_next = lobm_pkg::ST_IDLE;
          endcase
        end
      end
      lobm_pkg::ST_ID_SCAN: begin
        if (scan_done) begin
          state_next = lobm_pkg::ST_ID_DONE;
        end
      end
      lobm_pkg::ST_ID_DONE: state_next = lobm_pkg::ST_TOP_SCAN;
      lobm_pkg::ST_PICK_SCAN: begin
        if (scan_done) begin
          state_next = pick_found ? lobm_pkg::ST_FILL : lobm_pkg::ST_TOP_SCAN;
        end
      end
      lobm_pkg::ST_FILL: begin
        state_next = more_fills ? lobm_pkg::ST_PICK_SCAN : lobm_pkg::ST_TOP_SCAN;
      end
      lobm_pkg::ST_TOP_SCAN: begin
        if (scan_done) begin
          state_next = lobm_pkg::ST_EMIT_RD;
        end
      end
      lobm_pkg::ST_EMIT_RD: state_next = lobm_pkg::ST_EMIT_LD;
      lobm_pkg::ST_EMIT_LD: state_next = lobm_pkg::ST_EMIT_WAIT;
      lobm_pkg::ST_EMIT_WAIT: begin
        if (rsp.ready) begin
          state_next = emit_last ? lobm_pkg::ST_IDLE : lobm_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = lobm_pkg::ST_IDLE;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    req.ready  = (state == lobm_pkg::ST_IDLE);
    slot_raddr = issue_idx[lobm_pkg::SLOT_BITS-1:0];
    fill_raddr = emit_idx[lobm_pkg::SLOT_BITS-1:0];
    slot_we    = 1'b0;
    slot_waddr = free_idx;
    slot_wdata = '{id: id_q, side: side_q, price: price_q, rem: left, stamp: seq_inc};
    fill_we    = 1'b0;
    fill_waddr = fill_cnt[lobm_pkg::SLOT_BITS-1:0];
    fill_wdata = '{id: pick_rec.id, price: pick_rec.price, qty: fq, stamp: seq_inc};
    case (state)
      lobm_pkg::ST_ID_DONE: begin
        slot_we = (op_q == lobm_pkg::OP_ADD) && add_ok;
      end
      lobm_pkg::ST_FILL: begin
        slot_we    = 1'b1;
        slot_waddr = pick_idx;
        slot_wdata = pick_rec;
        slot_wdata.rem = rem_after;
        fill_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lobm_pkg::ST_IDLE;
      valid_bits <= '0;
      seq        <= '0;
      pipe_vld   <= 1'b0;
      fill_cnt   <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;

      // Scan counters restart whenever a scan state is entered.
      if ((state_next == lobm_pkg::ST_ID_SCAN || state_next == lobm_pkg::ST_PICK_SCAN ||
           state_next == lobm_pkg::ST_TOP_SCAN) && state_next != state) begin
        issue_idx  <= '0;
        pipe_vld   <= 1'b0;
        pick_found <= 1'b0;
        bid_found  <= 1'b0;
        ask_found  <= 1'b0;
      end else if (state == lobm_pkg::ST_ID_SCAN || state == lobm_pkg::ST_PICK_SCAN ||
                   state == lobm_pkg::ST_TOP_SCAN) begin
        pipe_vld <= issuing;
        pipe_idx <= issue_idx[lobm_pkg::SLOT_BITS-1:0];
        if (issuing) begin
          issue_idx <= issue_idx + lobm_pkg::CNT_BITS'(1);
        end
      end

      case (state)
        lobm_pkg::ST_IDLE: begin
          if (req.valid) begin
            op_q       <= lobm_pkg::op_t'(req.op);
            id_q       <= req.order_id;
            side_q     <= req.side;
            price_q    <= req.price_ticks;
            left       <= req.quantity;
            hit        <= 1'b0;
            free_found <= 1'b0;
            fill_cnt   <= '0;
            emit_idx   <= '0;
            if (lobm_pkg::op_t'(req.op) == lobm_pkg::OP_MARKET) begin
              seq   <= seq_inc;
              taker <= seq_inc;
            end
          end
        end
        lobm_pkg::ST_ID_SCAN: begin
          if (cand && slot_rd.id == id_q && !hit) begin
            hit     <= 1'b1;
            hit_idx <= pipe_idx;
          end
          if (pipe_vld && !valid_bits[pipe_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= pipe_idx;
          end
        end
        lobm_pkg::ST_ID_DONE: begin
          if (op_q == lobm_pkg::OP_ADD) begin
            accepted_q <= add_ok;
            if (add_ok) begin
              valid_bits[free_idx] <= 1'b1;
              seq                  <= seq_inc;
            end
          end else begin
            accepted_q <= hit;
            if (hit) begin
              valid_bits[hit_idx] <= 1'b0;
            end
          end
        end
        lobm_pkg::ST_PICK_SCAN: begin
          if (cand && slot_rd.side != side_q && better) begin
            pick_found <= 1'b1;
            pick_idx   <= pipe_idx;
            pick_rec   <= slot_rd;
            pick_age   <= age;
          end
        end
        lobm_pkg::ST_FILL: begin
          seq      <= seq_inc;
          left     <= left_after;
          fill_cnt <= cnt_inc;
          if (rem_after == '0) begin
            valid_bits[pick_idx] <= 1'b0;
          end
        end
        lobm_pkg::ST_TOP_SCAN: begin
          if (cand && !slot_rd.side) begin
            if (!bid_found || slot_rd.price > bb) begin
              bid_found <= 1'b1;
              bb        <= slot_rd.price;
              bq        <= lobm_pkg::LVL_BITS'(slot_rd.rem);
            end else if (slot_rd.price == bb) begin
              bq <= bq + lobm_pkg::LVL_BITS'(slot_rd.rem);
            end
          end
          if (cand && slot_rd.side) begin
            if (!ask_found || slot_rd.price < ba) begin
              ask_found <= 1'b1;
              ba        <= slot_rd.price;
              aq        <= lobm_pkg::LVL_BITS'(slot_rd.rem);
            end else if (slot_rd.price == ba) begin
              aq <= aq + lobm_pkg::LVL_BITS'(slot_rd.rem);
            end
          end
        end
        lobm_pkg::ST_EMIT_LD: begin
          rsp.valid    <= 1'b1;
          rsp.best_bid <= bid_found ? bb : '0;
          rsp.bid_qty  <= bid_found ? bq : '0;
          rsp.best_ask <= ask_found ? ba : '1;
          rsp.ask_qty  <= ask_found ? aq : '0;
          rsp.last     <= emit_last;
          if (op_q == lobm_pkg::OP_MARKET) begin
            rsp.taker_id <= taker;
            if (fill_cnt != '0) begin
              rsp.kind        <= lobm_pkg::KIND_FILL;
              rsp.accepted    <= 1'b1;
              rsp.resting_id  <= fill_rd.id;
              rsp.fill_price  <= fill_rd.price;
              rsp.fill_qty    <= fill_rd.qty;
              rsp.trade_stamp <= fill_rd.stamp;
            end else begin
              rsp.kind        <= lobm_pkg::KIND_NOFILL;
              rsp.accepted    <= 1'b0;
              rsp.resting_id  <= '0;
              rsp.fill_price  <= '0;
              rsp.fill_qty    <= '0;
              rsp.trade_stamp <= '0;
            end
          end else begin
            rsp.kind        <= (op_q == lobm_pkg::OP_ADD) ? lobm_pkg::KIND_ADD
                                                          : lobm_pkg::KIND_CANCEL;
            rsp.accepted    <= accepted_q;
            rsp.resting_id  <= id_q;
            rsp.taker_id    <= '0;
            rsp.fill_price  <= '0;
            rsp.fill_qty    <= '0;
            rsp.trade_stamp <= '0;
          end
        end
        lobm_pkg::ST_EMIT_WAIT: begin
          if (rsp.ready) begin
            rsp.valid <= 1'b0;
            emit_idx  <= emit_idx + lobm_pkg::CNT_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A new command is never taken while a result item is still on offer.
  `LOBM_ASSERT_IMPL(a_no_accept_while_busy, rsp.valid, !req.ready,
                    "command accepted while a result item is pending")
  // Once a defined command is taken the block is still busy in the next cycle.
  `LOBM_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready && (req.op == lobm_pkg::OP_ADD || req.op == lobm_pkg::OP_CANCEL || req.op == lobm_pkg::OP_MARKET),
                    !req.ready, "block ready again straight after an accept")
  // A fill always trades a non-zero quantity and reports itself as accepted.
  `LOBM_ASSERT_IMPL(a_fill_nonzero, rsp.valid && rsp.kind == lobm_pkg::KIND_FILL,
                    rsp.fill_qty != '0 && rsp.accepted, "fill with zero quantity")
  // The fill buffer never overflows.
  `LOBM_ASSERT_IMPL(a_fill_bound, 1'b1,
                    fill_cnt <= lobm_pkg::CNT_BITS'(lobm_pkg::ORDER_SLOTS),
                    "fill count beyond table size")

endmodule

// File: rtl/lobm_ram.sv
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sim/testbench.sv
// Testbench for limit_order_book_matcher_core.
// Commands go in on the req channel and result items come back on rsp. A book
// model kept in the scoreboard class predicts every result item of each
// accepted command, and each result item taken from the block is compared
// with the oldest prediction still waiting.
module testbench;

  // The command encoding leaves one code undefined; the block must drop it.
  localparam logic [1:0] OP_UNDEF = 2'd3;
  localparam logic [lobm_pkg::PRICE_BITS-1:0] PRICE_TOP = '1;
  localparam logic [lobm_pkg::QTY_BITS-1:0] QTY_TOP = '1;

  // One result item, laid out field by field as the rsp channel carries it.
  typedef struct packed {
    logic [1:0]                      kind;
    logic                            accepted;
    logic [lobm_pkg::ID_BITS-1:0]    resting_id;
    logic [lobm_pkg::SEQ_BITS-1:0]   taker_id;
    logic [lobm_pkg::PRICE_BITS-1:0] fill_price;
    logic [lobm_pkg::QTY_BITS-1:0]   fill_qty;
    logic [lobm_pkg::SEQ_BITS-1:0]   trade_stamp;
    logic [lobm_pkg::PRICE_BITS-1:0] best_bid;
    logic [lobm_pkg::LVL_BITS-1:0]   bid_qty;
    logic [lobm_pkg::PRICE_BITS-1:0] best_ask;
    logic [lobm_pkg::LVL_BITS-1:0]   ask_qty;
    logic                            last;
  } book_result_t;

  // Book model and the queue of result items it still expects from the block.
  class book_scoreboard;
    bit                              used[lobm_pkg::ORDER_SLOTS];
    logic [lobm_pkg::ID_BITS-1:0]    oid[lobm_pkg::ORDER_SLOTS];
    logic                            oside[lobm_pkg::ORDER_SLOTS];
    logic [lobm_pkg::PRICE_BITS-1:0] oprice[lobm_pkg::ORDER_SLOTS];
    logic [lobm_pkg::QTY_BITS-1:0]   orem[lobm_pkg::ORDER_SLOTS];
    logic [lobm_pkg::SEQ_BITS-1:0]   ostamp[lobm_pkg::ORDER_SLOTS];
    logic [lobm_pkg::SEQ_BITS-1:0]   seq_count;
    book_result_t                    awaited[$];
    int mismatches;
    int unexpected;
    int fills;
    int no_fills;
    int rejects;
    int taken;

    function new();
      foreach (used[i]) used[i] = 0;
      seq_count = '0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int find_order(logic [lobm_pkg::ID_BITS-1:0] id);
      for (int i = 0; i < lobm_pkg::ORDER_SLOTS; i++)
        if (used[i] && oid[i] == id) return i;
      return -1;
    endfunction

    // Best price of one side and the total quantity resting there.
    function bit side_top(logic sd, output logic [lobm_pkg::PRICE_BITS-1:0] px,
                          output logic [lobm_pkg::LVL_BITS-1:0] qty);
      bit found;
      logic [63:0] sum;
      found = 0;
      px = '0;
      sum = '0;
      for (int i = 0; i < lobm_pkg::ORDER_SLOTS; i++) begin
        if (used[i] && oside[i] == sd &&
            (!found || (sd == 1'b0 ? oprice[i] > px : oprice[i] < px))) begin
          found = 1;
          px = oprice[i];
        end
      end
      for (int i = 0; i < lobm_pkg::ORDER_SLOTS; i++)
        if (found && used[i] && oside[i] == sd && oprice[i] == px) sum += 64'(orem[i]);
      qty = sum[lobm_pkg::LVL_BITS-1:0];
      return found;
    endfunction

    // Oldest order at the best price of one side; age survives counter wrap.
    function int front_order(logic sd);
      logic [lobm_pkg::PRICE_BITS-1:0] px;
      logic [lobm_pkg::LVL_BITS-1:0] qty;
      logic [lobm_pkg::SEQ_BITS-1:0] age;
      logic [lobm_pkg::SEQ_BITS-1:0] best_age;
      int pick;
      pick = -1;
      best_age = '0;
      if (!side_top(sd, px, qty)) return -1;
      for (int i = 0; i < lobm_pkg::ORDER_SLOTS; i++) begin
        if (used[i] && oside[i] == sd && oprice[i] == px) begin
          age = seq_count - ostamp[i];
          if (pick < 0 || age > best_age) begin
            pick = i;
            best_age = age;
          end
        end
      end
      return pick;
    endfunction

    // Called for each command item the block accepts.
    function void note(logic [1:0] op, logic [lobm_pkg::ID_BITS-1:0] id, logic sd,
                       logic [lobm_pkg::PRICE_BITS-1:0] px,
                       logic [lobm_pkg::QTY_BITS-1:0] qty);
      book_result_t step[$];
      book_result_t e;
      int s;
      logic [lobm_pkg::SEQ_BITS-1:0] taker;
      logic [lobm_pkg::QTY_BITS-1:0] left;
      logic [lobm_pkg::QTY_BITS-1:0] fq;
      logic [lobm_pkg::PRICE_BITS-1:0] bb;
      logic [lobm_pkg::PRICE_BITS-1:0] ba;
      logic [lobm_pkg::LVL_BITS-1:0] bq;
      logic [lobm_pkg::LVL_BITS-1:0] aq;
      e = '0;
      if (op == lobm_pkg::OP_ADD) begin
        e.kind = lobm_pkg::KIND_ADD;
        e.resting_id = id;
        s = -1;
        if (qty != 0 && px != 0 && find_order(id) < 0)
          for (int i = lobm_pkg::ORDER_SLOTS - 1; i >= 0; i--)
            if (!used[i]) s = i;
        if (s >= 0) begin
          seq_count = seq_count + 1'b1;
          used[s] = 1;
          oid[s] = id;
          oside[s] = sd;
          oprice[s] = px;
          orem[s] = qty;
          ostamp[s] = seq_count;
          e.accepted = 1'b1;
        end else begin
          rejects++;
        end
        step = {step, e};
      end else if (op == lobm_pkg::OP_CANCEL) begin
        e.kind = lobm_pkg::KIND_CANCEL;
        e.resting_id = id;
        s = find_order(id);
        if (s >= 0) begin
          used[s] = 0;
          e.accepted = 1'b1;
        end else begin
          rejects++;
        end
        step = {step, e};
      end else if (op == lobm_pkg::OP_MARKET) begin
        seq_count = seq_count + 1'b1;
        taker = seq_count;
        left = qty;
        while (left != 0 && step.size() < lobm_pkg::ORDER_SLOTS) begin
          s = front_order(~sd);
          if (s < 0) break;
          fq = (left < orem[s]) ? left : orem[s];
          seq_count = seq_count + 1'b1;
          e = '0;
          e.kind = lobm_pkg::KIND_FILL;
          e.accepted = 1'b1;
          e.resting_id = oid[s];
          e.taker_id = taker;
          e.fill_price = oprice[s];
          e.fill_qty = fq;
          e.trade_stamp = seq_count;
          step = {step, e};
          orem[s] = orem[s] - fq;
          left = left - fq;
          if (orem[s] == 0) used[s] = 0;
        end
        fills += step.size();
        if (step.size() == 0) begin
          e = '0;
          e.kind = lobm_pkg::KIND_NOFILL;
          e.taker_id = taker;
          step = {step, e};
          no_fills++;
        end
      end else begin
        return;
      end
      if (!side_top(1'b0, bb, bq)) begin
        bb = '0;
        bq = '0;
      end
      if (!side_top(1'b1, ba, aq)) begin
        ba = PRICE_TOP;
        aq = '0;
      end
      foreach (step[k]) begin
        step[k].best_bid = bb;
        step[k].bid_qty = bq;
        step[k].best_ask = ba;
        step[k].ask_qty = aq;
        step[k].last = (k == step.size() - 1);
        awaited = {awaited, step[k]};
      end
    endfunction

    // Called for each result item taken from the block.
    function void check(book_result_t got);
      book_result_t e;
      taken++;
      if (awaited.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result item: %p", got);
        return;
      end
      e = awaited.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches + unexpected <= 10) begin
          $display("result item %0d differs", taken);
          $display("  expected %p", e);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  lobm_in_if  req_ch();
  lobm_out_if rsp_ch();

  limit_order_book_matcher_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  book_scoreboard book;
  bit quiet;          // no idling on either side in the closing stretch
  int hold_request;   // cycles for which the receiver is to refuse results
  int commands_sent;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #8000000;
    $display("timeout with %0d result items still awaited", book.pending());
    $display("** limit_order_book_matcher_core: FAILED **");
    $finish;
  end

  // Result side: ready changes on the falling edge, items are checked on the
  // rising edge. Stalls come in short bursts, plus one long hold on request.
  initial begin
    int burst;
    int hold;
    book_result_t got;
    burst = 0;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.kind = rsp_ch.kind;
        got.accepted = rsp_ch.accepted;
        got.resting_id = rsp_ch.resting_id;
        got.taker_id = rsp_ch.taker_id;
        got.fill_price = rsp_ch.fill_price;
        got.fill_qty = rsp_ch.fill_qty;
        got.trade_stamp = rsp_ch.trade_stamp;
        got.best_bid = rsp_ch.best_bid;
        got.bid_qty = rsp_ch.bid_qty;
        got.best_ask = rsp_ch.best_ask;
        got.ask_qty = rsp_ch.ask_qty;
        got.last = rsp_ch.last;
        book.check(got);
      end
      @(negedge clk);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready = 1'b0;
      end else if (burst > 0) begin
        burst--;
        rsp_ch.ready = 1'b0;
      end else if (!quiet && $urandom_range(5) == 0) begin
        burst = $urandom_range(7);
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // Offers one command item from a falling edge and returns on the falling
  // edge after it is taken. valid stays high when the next item follows at once.
  task automatic send_command(logic [1:0] op, logic [lobm_pkg::ID_BITS-1:0] id, logic sd,
                              logic [lobm_pkg::PRICE_BITS-1:0] px,
                              logic [lobm_pkg::QTY_BITS-1:0] qty);
    int gap;
    if (!quiet && $urandom_range(3) == 0) begin
      req_ch.valid = 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.op = op;
    req_ch.order_id = id;
    req_ch.side = sd;
    req_ch.price_ticks = px;
    req_ch.quantity = qty;
    do @(posedge clk); while (!req_ch.ready);
    book.note(op, id, sd, px, qty);
    commands_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_ch.valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    // Leave the block idle for a while before going on.
    repeat (300) @(negedge clk);
  endtask

  function automatic logic [lobm_pkg::ID_BITS-1:0] wide_id();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [1:0] op;
    logic [lobm_pkg::ID_BITS-1:0] id;
    logic [lobm_pkg::QTY_BITS-1:0] qty;
    int pick;
    book = new();
    quiet = 0;
    hold_request = 0;
    commands_sent = 0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = lobm_pkg::OP_ADD;
    req_ch.order_id = '0;
    req_ch.side = 1'b0;
    req_ch.price_ticks = '0;
    req_ch.quantity = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: rejections, an empty opposite side, priority by age,
    // an ask resting at the very top price, extreme quantities and the
    // undefined command code.
    send_command(lobm_pkg::OP_ADD, 64'd1, 1'b0, 20'd100, 32'd10);
    send_command(lobm_pkg::OP_ADD, 64'd2, 1'b1, 20'd200, 32'd5);
    send_command(lobm_pkg::OP_ADD, 64'd5, 1'b0, 20'd100, 32'd0);
    send_command(lobm_pkg::OP_ADD, 64'd6, 1'b1, 20'd0, 32'd7);
    send_command(lobm_pkg::OP_ADD, 64'd1, 1'b1, 20'd300, 32'd3);
    send_command(lobm_pkg::OP_CANCEL, 64'd77, 1'b0, 20'd0, 32'd0);
    send_command(lobm_pkg::OP_CANCEL, 64'd2, 1'b1, 20'd0, 32'd0);
    send_command(lobm_pkg::OP_MARKET, 64'd0, 1'b0, 20'd0, 32'd4);
    send_command(lobm_pkg::OP_ADD, '1, 1'b1, PRICE_TOP, 32'd9);
    send_command(lobm_pkg::OP_MARKET, '1, 1'b0, PRICE_TOP, 32'd0);
    send_command(lobm_pkg::OP_ADD, 64'd3, 1'b0, 20'd100, 32'd8);
    send_command(lobm_pkg::OP_ADD, 64'd4, 1'b0, 20'd100, 32'd8);
    send_command(lobm_pkg::OP_ADD, 64'd0, 1'b0, 20'd1, QTY_TOP);
    send_command(lobm_pkg::OP_MARKET, 64'd0, 1'b1, 20'd0, 32'd25);
    send_command(OP_UNDEF, 64'd9, 1'b1, 20'd50, 32'd50);
    send_command(lobm_pkg::OP_ADD, 64'd10, 1'b1, 20'd150, QTY_TOP);
    send_command(lobm_pkg::OP_MARKET, 64'd0, 1'b0, 20'd0, QTY_TOP);
    send_command(lobm_pkg::OP_MARKET, 64'd0, 1'b1, 20'd0, QTY_TOP);
    send_command(lobm_pkg::OP_MARKET, 64'd0, 1'b1, 20'd0, 32'd1);

    // Wait for the block to settle before the fill-up phase.
    drain_results();

    // Fill the table past capacity while the receiver holds off for a long
    // stretch, so that the block backs up and stalls its command input.
    hold_request = 600;
    for (int i = 0; i < 66; i++)
      send_command(lobm_pkg::OP_ADD, 64'd1000 + 64'(i), 1'($urandom_range(1)),
                   lobm_pkg::PRICE_BITS'(500 + $urandom_range(16)),
                   lobm_pkg::QTY_BITS'($urandom_range(1, 200)));
    drain_results();

    // Random mix of adds, cancels and market orders over a small id pool so
    // that cancels and duplicates often hit; the last few with no idling.
    for (int i = 0; i < 25; i++) begin
      if (i == 18) quiet = 1;
      pick = $urandom_range(99);
      if (pick < 4) op = OP_UNDEF;
      else if (pick < 40) op = lobm_pkg::OP_ADD;
      else if (pick < 65) op = lobm_pkg::OP_CANCEL;
      else op = lobm_pkg::OP_MARKET;
      id = ($urandom_range(4) == 0) ? wide_id() : 64'd1000 + 64'($urandom_range(70));
      case ($urandom_range(3))
        0: qty = $urandom();
        1: qty = lobm_pkg::QTY_BITS'($urandom_range(1, 400));
        default: qty = lobm_pkg::QTY_BITS'($urandom_range(1, 60));
      endcase
      send_command(op, id, 1'($urandom_range(1)),
                   ($urandom_range(5) == 0) ? lobm_pkg::PRICE_BITS'($urandom())
                                            : lobm_pkg::PRICE_BITS'(500 + $urandom_range(16)),
                   qty);
    end

    req_ch.valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (300) @(negedge clk);

    $display("%0d commands sent, %0d result items checked: %0d fills, %0d market orders",
             commands_sent, book.taken, book.fills, book.no_fills);
    $display("  without a fill, %0d rejected adds or cancels", book.rejects);
    if (book.mismatches == 0 && book.unexpected == 0 && book.pending() == 0) begin
      $display("** limit_order_book_matcher_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d unexpected result items", book.mismatches,
               book.unexpected);
      $display("** limit_order_book_matcher_core: FAILED **");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/lobm_pkg.sv
rtl/lobm_if.sv
rtl/lobm_ram.sv
rtl/limit_order_book_matcher_core.sv
sim/testbench.sv
